// ===== rtl/coesc_pkg.sv =====
// shared types and constants for the cursor override escape scanner
package coesc_pkg;

    // default depth of the parameter digit buffer
    localparam int PARAM_BUFFER_SIZE = 16;

    // value at which the decimal parameter stops growing
    localparam logic [19:0] VALUE_CAP = 20'd100000;

    // parameter values and bounds that select special actions
    localparam logic [19:0] PARAM_BLINK_MODE = 20'd12;
    localparam logic [19:0] PARAM_ALT_1049   = 20'd1049;
    localparam logic [19:0] PARAM_ALT_1047   = 20'd1047;
    localparam logic [19:0] PARAM_ALT_47     = 20'd47;
    localparam logic [19:0] PARAM_STYLE_MAX  = 20'd6;

    // byte codes
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_C  = 8'h63;
    localparam logic [7:0] CH_LC_Q  = 8'h71;
    localparam logic [7:0] CH_LC_H  = 8'h68;
    localparam logic [7:0] CH_LC_L  = 8'h6C;
    localparam logic [7:0] CH_LC_P  = 8'h70;

    // scan states
    typedef enum logic [2:0] {
        ST_NORMAL = 3'd0,
        ST_ESC    = 3'd1,
        ST_CSI    = 3'd2,
        ST_SP     = 3'd3,
        ST_PRIV   = 3'd4,
        ST_BANG   = 3'd5
    } t_scan_state;

    // one result word
    typedef struct packed {
        logic valid;
        logic style;
        logic blink;
    } t_flag_word;

endpackage

// ===== rtl/cursor_override_escape_scanner_top.sv =====
// cursor override escape scanner: byte scan state machine with two-entry output buffer
// an accepted byte's flags go to the output register, or to the skid slot while a result waits there
// throughput: one byte per cycle while the skid slot is empty; input ready drops while it is full
// two output slots (result register plus skid) keep input ready while one result waits
// synchronous active-low reset: scan state normal text, parameter zero, both flags zero,
// output buffer empty
module cursor_override_escape_scanner_top #(
    parameter int PARAM_BUFFER_SIZE = coesc_pkg::PARAM_BUFFER_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_stream_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_style_overridden,
    output logic       o_blink_overridden
);
    import coesc_pkg::*;

    localparam int CW = $clog2(PARAM_BUFFER_SIZE);

    t_scan_state   r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [19:0]   r_value, n_value;
    logic          r_style, n_style;
    logic          r_blink, n_blink;
    t_flag_word    r_out, n_out;
    t_flag_word    r_skd, n_skd;

    logic          accept;
    logic          is_digit;
    logic          keep_digit;
    logic [19:0]   digit_value;
    logic [19:0]   grown_value;
    t_flag_word    new_word;

    assign accept   = i_in_valid && o_in_ready;
    assign is_digit = (i_stream_byte >= CH_ZERO) && (i_stream_byte <= CH_NINE);

    // digit accumulation with buffer limit and value cap
    assign keep_digit  = r_count < CW'(PARAM_BUFFER_SIZE - 1);
    assign digit_value = {16'd0, i_stream_byte[3:0]};
    assign grown_value = (r_value < VALUE_CAP)
                       ? (r_value << 3) + (r_value << 1) + digit_value
                       : r_value;

    // scan state update for one byte
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_value = r_value;
        n_style = r_style;
        n_blink = r_blink;
        if (accept) begin
            case (r_state)
                ST_NORMAL: begin
                    if (i_stream_byte == CH_ESC) n_state = ST_ESC;
                end
                ST_ESC: begin
                    if (i_stream_byte == CH_LC_C) begin
                        n_style = 1'b0;
                        n_blink = 1'b0;
                        n_state = ST_NORMAL;
                    end else if (i_stream_byte == CH_LBRK) begin
                        n_count = '0;
                        n_value = '0;
                        n_state = ST_CSI;
                    end else if (i_stream_byte != CH_ESC) begin
                        n_state = ST_NORMAL;
                    end
                end
                ST_CSI: begin
                    if (is_digit) begin
                        if (keep_digit) begin
                            n_count = r_count + 1'b1;
                            n_value = grown_value;
                        end
                    end else if (i_stream_byte == CH_SPACE) begin
                        n_state = ST_SP;
                    end else if (i_stream_byte == CH_QUEST) begin
                        n_count = '0;
                        n_value = '0;
                        n_state = ST_PRIV;
                    end else if (i_stream_byte == CH_BANG) begin
                        n_state = ST_BANG;
                    end else if (i_stream_byte == CH_ESC) begin
                        n_state = ST_ESC;
                    end else begin
                        n_state = ST_NORMAL;
                    end
                end
                ST_SP: begin
                    if (i_stream_byte == CH_LC_Q) begin
                        if ((r_value != '0) && (r_value <= PARAM_STYLE_MAX)) begin
                            n_style = 1'b1;
                            n_blink = 1'b1;
                        end else begin
                            n_style = 1'b0;
                            n_blink = 1'b0;
                        end
                        n_state = ST_NORMAL;
                    end else if (i_stream_byte == CH_ESC) begin
                        n_state = ST_ESC;
                    end else begin
                        n_state = ST_NORMAL;
                    end
                end
                ST_PRIV: begin
                    if (is_digit) begin
                        if (keep_digit) begin
                            n_count = r_count + 1'b1;
                            n_value = grown_value;
                        end
                    end else if (i_stream_byte == CH_LC_H) begin
                        if (r_value == PARAM_BLINK_MODE) n_blink = 1'b1;
                        n_state = ST_NORMAL;
                    end else if (i_stream_byte == CH_LC_L) begin
                        if (r_value == PARAM_BLINK_MODE) begin
                            n_blink = 1'b0;
                        end else if ((r_value == PARAM_ALT_1049) ||
                                     (r_value == PARAM_ALT_1047) ||
                                     (r_value == PARAM_ALT_47)) begin
                            n_style = 1'b0;
                            n_blink = 1'b0;
                        end
                        n_state = ST_NORMAL;
                    end else if (i_stream_byte == CH_ESC) begin
                        n_state = ST_ESC;
                    end else begin
                        n_state = ST_NORMAL;
                    end
                end
                ST_BANG: begin
                    if (i_stream_byte == CH_LC_P) begin
                        n_style = 1'b0;
                        n_blink = 1'b0;
                        n_state = ST_NORMAL;
                    end else if (i_stream_byte == CH_ESC) begin
                        n_state = ST_ESC;
                    end else begin
                        n_state = ST_NORMAL;
                    end
                end
                default: begin
                    n_state = ST_NORMAL;
                end
            endcase
        end
    end

    // result word for the accepted byte
    assign new_word = '{valid: accept, style: n_style, blink: n_blink};

    // output register and skid slot
    assign o_in_ready = !r_skd.valid;

    always_comb begin
        n_out = r_out;
        n_skd = r_skd;
        if (!r_out.valid || i_out_ready) begin
            if (r_skd.valid) begin
                n_out = r_skd;
                n_skd = new_word;
            end else begin
                n_out = new_word;
            end
        end else if (accept) begin
            n_skd = new_word;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_NORMAL;
            r_count   <= '0;
            r_value   <= '0;
            r_style   <= 1'b0;
            r_blink   <= 1'b0;
            r_out     <= '0;
            r_skd     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_value   <= n_value;
            r_style   <= n_style;
            r_blink   <= n_blink;
            r_out     <= n_out;
            r_skd     <= n_skd;
        end
    end

    assign o_out_valid        = r_out.valid;
    assign o_style_overridden = r_out.style;
    assign o_blink_overridden = r_out.blink;

endmodule
